// ===== hw/rtl/sab_pkg.sv =====
// ----------------------------------------------------------------------------
// Sector allocation bitmap package
// Field widths, command codes, controller states and the result record
// shared by the allocation bitmap modules.
// ----------------------------------------------------------------------------
package sab_pkg;

    localparam int CMD_W    = 3;
    localparam int TRACK_W  = 6;
    localparam int SECTOR_W = 4;
    localparam int FB_W     = 17;

    localparam logic [CMD_W-1:0] CMD_MARK_USED  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MARK_FREE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND_FREE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FREE_SPACE = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_SCAN,
        ST_DONE
    } sab_state_t;

    typedef struct packed {
        logic                is_used;
        logic [TRACK_W-1:0]  found_track;
        logic [SECTOR_W-1:0] found_sector;
        logic                no_space;
        logic [FB_W-1:0]     free_bytes;
        logic                bad_address;
    } sab_res_t;

endpackage

// ===== hw/rtl/sector_allocation_bitmap_core.sv =====
// Free space, unused codes and bad addresses go from accept straight to the done
// state; mark and query pass through read-modify-write, a find through the scan,
// and the result then goes through the output register to m_valid. A new beat is
// taken only once the engine is idle; a find reads one track word per cycle.
// Reset clears the map through per-track valid bits at once, with no clearing pass.
// ----------------------------------------------------------------------------
// Sector allocation bitmap core
// Used/free bit per sector, held in a track-word RAM, with mark, query,
// find-first-free and free-space commands and a registered result stage.
// ----------------------------------------------------------------------------
module sector_allocation_bitmap_core #(
    parameter int DATA_TRACKS       = 39,
    parameter int SECTORS_PER_TRACK = 16,
    parameter int BYTES_PER_SECTOR  = 126,
    localparam int AW = (DATA_TRACKS > 1) ? $clog2(DATA_TRACKS) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sab_pkg::CMD_W-1:0]     s_cmd,
    input  logic [sab_pkg::TRACK_W-1:0]   s_track,
    input  logic [sab_pkg::SECTOR_W-1:0]  s_sector,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_is_used,
    output logic [sab_pkg::TRACK_W-1:0]   m_found_track,
    output logic [sab_pkg::SECTOR_W-1:0]  m_found_sector,
    output logic                          m_no_space,
    output logic [sab_pkg::FB_W-1:0]      m_free_bytes,
    output logic                          m_bad_address
);

    logic                         ram_wr_en;
    logic [AW-1:0]                ram_wr_addr;
    logic [SECTORS_PER_TRACK-1:0] ram_wr_data;
    logic [AW-1:0]                ram_rd_addr;
    logic [SECTORS_PER_TRACK-1:0] ram_rd_data;
    logic                         res_valid;
    logic                         res_ready;
    sab_pkg::sab_res_t            res;
    sab_pkg::sab_res_t            out_reg;
    logic                         out_vld_reg;

    sab_ram #(
        .WIDTH (SECTORS_PER_TRACK),
        .DEPTH (DATA_TRACKS)
    ) u_map_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    sab_engine #(
        .DATA_TRACKS       (DATA_TRACKS),
        .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
        .BYTES_PER_SECTOR  (BYTES_PER_SECTOR)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_cmd      (s_cmd),
        .in_track    (s_track),
        .in_sector   (s_sector),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // The output register frees the engine while a result beat waits downstream.
    assign res_ready = !out_vld_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (res_ready) begin
            out_vld_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_is_used      = out_reg.is_used;
    assign m_found_track  = out_reg.found_track;
    assign m_found_sector = out_reg.found_sector;
    assign m_no_space     = out_reg.no_space;
    assign m_free_bytes   = out_reg.free_bytes;
    assign m_bad_address  = out_reg.bad_address;

    a_handoff: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |=> m_valid)
        else $error("result beat from the engine was not registered");

    a_no_space_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_no_space) |-> (m_found_track == '0 && m_found_sector == '0))
        else $error("no space reported together with a found sector");

    a_bad_addr_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_address) |-> (!m_is_used && !m_no_space && m_found_track == '0))
        else $error("bad address beat carries query or find results");

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !res_valid)
        else $error("new beat accepted while the engine holds a result");

endmodule

// ===== hw/rtl/sab_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module sab_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 39,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/sab_engine.sv =====
// ----------------------------------------------------------------------------
// Allocation bitmap engine
// Sequencer that reads, modifies and writes back track words, scans them for
// the first free sector and keeps the count of used sectors.
// ----------------------------------------------------------------------------
module sab_engine #(
    parameter int DATA_TRACKS       = 39,
    parameter int SECTORS_PER_TRACK = 16,
    parameter int BYTES_PER_SECTOR  = 126,
    localparam int AW    = (DATA_TRACKS > 1) ? $clog2(DATA_TRACKS) : 1,
    localparam int SW    = (SECTORS_PER_TRACK > 1) ? $clog2(SECTORS_PER_TRACK) : 1,
    localparam int TOTAL = DATA_TRACKS * SECTORS_PER_TRACK,
    localparam int CNT_W = $clog2(TOTAL + 1),
    localparam int BPS_W = $clog2(BYTES_PER_SECTOR + 1),
    localparam int PROD_W = CNT_W + BPS_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sab_pkg::CMD_W-1:0]     in_cmd,
    input  logic [sab_pkg::TRACK_W-1:0]   in_track,
    input  logic [sab_pkg::SECTOR_W-1:0]  in_sector,
    output logic                          ram_wr_en,
    output logic [AW-1:0]                 ram_wr_addr,
    output logic [SECTORS_PER_TRACK-1:0]  ram_wr_data,
    output logic [AW-1:0]                 ram_rd_addr,
    input  logic [SECTORS_PER_TRACK-1:0]  ram_rd_data,
    output logic                          res_valid,
    input  logic                          res_ready,
    output sab_pkg::sab_res_t             res
);

    sab_pkg::sab_state_t state_reg, state_next;

    logic [sab_pkg::CMD_W-1:0]    cmd_reg;
    logic [sab_pkg::SECTOR_W-1:0] sec_reg;
    logic [AW-1:0]                addr_reg;
    logic [AW-1:0]                scan_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [DATA_TRACKS-1:0]       vld_reg;
    logic                         rvld_reg;
    sab_pkg::sab_res_t            res_reg;

    logic                         is_mark_cmd;
    logic [7:0]                   trk_ext;
    logic                         addr_ok;
    logic [AW-1:0]                mark_addr;
    sab_pkg::sab_res_t            res_start;
    logic [SECTORS_PER_TRACK-1:0] word;
    logic [SECTORS_PER_TRACK-1:0] bit_mask;
    logic [SECTORS_PER_TRACK-1:0] new_word;
    logic                         was_used;
    logic                         flip;
    logic                         free_any;
    logic [SW-1:0]                first_idx;
    logic                         scan_last;
    logic [8:0]                   found_trk;
    logic [CNT_W-1:0]             free_cnt;
    logic [PROD_W-1:0]            prod;

    // Address decode of the incoming beat.
    always_comb begin
        is_mark_cmd = in_cmd inside {sab_pkg::CMD_MARK_USED, sab_pkg::CMD_MARK_FREE,
                                     sab_pkg::CMD_QUERY};
        trk_ext   = 8'(in_track);
        addr_ok   = (in_track != '0) && (trk_ext <= 8'(DATA_TRACKS))
                    && (7'(in_sector) < 7'(SECTORS_PER_TRACK));
        mark_addr = addr_ok ? AW'(trk_ext - 8'd1) : '0;
        res_start             = '0;
        res_start.bad_address = is_mark_cmd && !addr_ok;
    end

    // A track word that has never been written reads as all free.
    always_comb begin
        word      = rvld_reg ? ram_rd_data : '0;
        bit_mask  = SECTORS_PER_TRACK'(1) << sec_reg;
        was_used  = |(word & bit_mask);
        flip      = ((cmd_reg == sab_pkg::CMD_MARK_USED) && !was_used)
                    || ((cmd_reg == sab_pkg::CMD_MARK_FREE) && was_used);
        new_word  = (cmd_reg == sab_pkg::CMD_MARK_USED) ? (word | bit_mask)
                                                        : (word & ~bit_mask);
        free_any  = ~&word;
        first_idx = '0;
        for (int i = SECTORS_PER_TRACK - 1; i >= 0; i--) begin
            if (!word[i]) begin
                first_idx = SW'(i);
            end
        end
        scan_last = (scan_reg == AW'(DATA_TRACKS - 1));
        found_trk = 9'(scan_reg) + 9'd1;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sab_pkg::ST_IDLE: begin
                if (in_valid) begin
                    if (is_mark_cmd) begin
                        state_next = addr_ok ? sab_pkg::ST_RMW : sab_pkg::ST_DONE;
                    end else if (in_cmd == sab_pkg::CMD_FIND_FREE) begin
                        state_next = sab_pkg::ST_SCAN;
                    end else begin
                        state_next = sab_pkg::ST_DONE;
                    end
                end
            end
            sab_pkg::ST_RMW: begin
                state_next = sab_pkg::ST_DONE;
            end
            sab_pkg::ST_SCAN: begin
                if (free_any || scan_last) begin
                    state_next = sab_pkg::ST_DONE;
                end
            end
            sab_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = sab_pkg::ST_IDLE;
                end
            end
            default: state_next = sab_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_rd_addr = addr_reg;
        case (state_reg)
            sab_pkg::ST_IDLE: begin
                in_ready    = 1'b1;
                ram_rd_addr = (in_cmd == sab_pkg::CMD_FIND_FREE) ? '0 : mark_addr;
            end
            sab_pkg::ST_RMW: begin
                ram_wr_en = flip;
            end
            sab_pkg::ST_SCAN: begin
                ram_rd_addr = scan_last ? scan_reg : scan_reg + AW'(1);
            end
            sab_pkg::ST_DONE: begin
                res_valid = 1'b1;
            end
            default: ;
        endcase
    end

    assign ram_wr_addr = addr_reg;
    assign ram_wr_data = new_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sab_pkg::ST_IDLE;
            cnt_reg   <= '0;
            vld_reg   <= '0;
            rvld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            rvld_reg  <= vld_reg[ram_rd_addr];
            if (ram_wr_en) begin
                vld_reg[addr_reg] <= 1'b1;
                if (cmd_reg == sab_pkg::CMD_MARK_USED) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end else if (cnt_reg != '0) begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            sab_pkg::ST_IDLE: begin
                if (in_valid) begin
                    cmd_reg  <= in_cmd;
                    sec_reg  <= in_sector;
                    addr_reg <= mark_addr;
                    scan_reg <= '0;
                    res_reg  <= res_start;
                end
            end
            sab_pkg::ST_RMW: begin
                if (cmd_reg == sab_pkg::CMD_QUERY) begin
                    res_reg.is_used <= was_used;
                end
            end
            sab_pkg::ST_SCAN: begin
                if (free_any) begin
                    res_reg.found_track  <= found_trk[sab_pkg::TRACK_W-1:0];
                    res_reg.found_sector <= sab_pkg::SECTOR_W'(first_idx);
                end else if (scan_last) begin
                    res_reg.no_space <= 1'b1;
                end else begin
                    scan_reg <= scan_reg + AW'(1);
                end
            end
            default: ;
        endcase
    end

    // Free space follows the count register; the product is registered at the output.
    always_comb begin
        free_cnt       = (cnt_reg <= CNT_W'(TOTAL)) ? CNT_W'(TOTAL) - cnt_reg : '0;
        prod           = PROD_W'(free_cnt) * PROD_W'(BYTES_PER_SECTOR);
        res            = res_reg;
        res.free_bytes = sab_pkg::FB_W'(prod);
    end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Sector allocation bitmap core testbench
// Sends mark, query, find-first-free and free-space commands, including a
// fill of the whole map, bad addresses and unused codes. Every accepted
// command is applied to a local copy of the map, and each result beat is
// compared field by field with the oldest predicted reply.
// ----------------------------------------------------------------------------
module testbench;
    import sab_pkg::*;

    localparam int DATA_TRACKS   = 39;
    localparam int SECTORS       = 16;
    localparam int SECTOR_BYTES  = 126;
    localparam int TOTAL_SECTORS = DATA_TRACKS * SECTORS;

    localparam logic [CMD_W-1:0]    CMD_TOP_CODE = '1;
    localparam logic [TRACK_W-1:0]  TRACK_MAX    = '1;
    localparam logic [SECTOR_W-1:0] SECTOR_MAX   = '1;

    localparam int TAIL_ITEMS     = 60;
    localparam int LONG_STALL     = 120;
    localparam int FIRST_STALL_AT = 60;
    localparam int STALL_SPACING  = 300;
    localparam int TAIL_CYCLES    = DATA_TRACKS + 10;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [TRACK_W-1:0]  track;
        logic [SECTOR_W-1:0] sector;
        bit                  drain_first;
    } map_cmd_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_cmd    = '0;
    logic [TRACK_W-1:0]  s_track  = '0;
    logic [SECTOR_W-1:0] s_sector = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_is_used;
    logic [TRACK_W-1:0]  m_found_track;
    logic [SECTOR_W-1:0] m_found_sector;
    logic                m_no_space;
    logic [FB_W-1:0]     m_free_bytes;
    logic                m_bad_address;

    sector_allocation_bitmap_core #(
        .DATA_TRACKS      (DATA_TRACKS),
        .SECTORS_PER_TRACK(SECTORS),
        .BYTES_PER_SECTOR (SECTOR_BYTES)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_track       (s_track),
        .s_sector      (s_sector),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_is_used     (m_is_used),
        .m_found_track (m_found_track),
        .m_found_sector(m_found_sector),
        .m_no_space    (m_no_space),
        .m_free_bytes  (m_free_bytes),
        .m_bad_address (m_bad_address)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Commands waiting to be sent, and replies predicted for accepted commands.
    map_cmd_t cmd_backlog[$];
    sab_res_t replies_due[$];

    // Local copy of the allocation map, updated as commands are accepted.
    bit [SECTORS-1:0] map_bits [1:DATA_TRACKS];
    int unsigned      sectors_used;

    // Shadow map used only while building the stimulus.
    bit [SECTORS-1:0] plan_bits [1:DATA_TRACKS];

    int  error_count  = 0;
    int  results_seen = 0;
    int  cmds_taken   = 0;
    int  finds_taken  = 0;
    int  finds_full   = 0;
    int  bad_taken    = 0;
    bit  in_taken     = 1'b0;
    bit  quiet_tail   = 1'b0;
    int  tx_gap       = 0;
    int  tx_idle_pct  = 15;
    int  rx_hold      = 0;
    int  rx_idle_pct  = 15;
    int  long_stalls  = 0;
    int  idle_cycles  = 0;

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    function automatic bit address_ok(logic [TRACK_W-1:0] track, logic [SECTOR_W-1:0] sector);
        return track >= 1 && track <= DATA_TRACKS && sector < SECTORS;
    endfunction

    // Applies one command to the local map and returns the reply it should give.
    function automatic sab_res_t apply_to_map(logic [CMD_W-1:0] cmd,
                                              logic [TRACK_W-1:0] track,
                                              logic [SECTOR_W-1:0] sector);
        sab_res_t r;
        bit       found;
        r     = '0;
        found = 1'b0;
        if (cmd == CMD_MARK_USED || cmd == CMD_MARK_FREE || cmd == CMD_QUERY) begin
            if (!address_ok(track, sector)) begin
                r.bad_address = 1'b1;
            end else if (cmd == CMD_MARK_USED && !map_bits[track][sector]) begin
                map_bits[track][sector] = 1'b1;
                sectors_used++;
            end else if (cmd == CMD_MARK_FREE && map_bits[track][sector]) begin
                map_bits[track][sector] = 1'b0;
                if (sectors_used > 0)
                    sectors_used--;
            end else if (cmd == CMD_QUERY) begin
                r.is_used = map_bits[track][sector];
            end
        end else if (cmd == CMD_FIND_FREE) begin
            for (int t = 1; t <= DATA_TRACKS; t++) begin
                for (int s = 0; s < SECTORS; s++) begin
                    if (!found && !map_bits[t][s]) begin
                        found          = 1'b1;
                        r.found_track  = TRACK_W'(t);
                        r.found_sector = SECTOR_W'(s);
                    end
                end
            end
            r.no_space = !found;
        end
        r.free_bytes = FB_W'((TOTAL_SECTORS - sectors_used) * SECTOR_BYTES);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [TRACK_W-1:0] track,
                             input logic [SECTOR_W-1:0] sector, input bit drain_first = 1'b0);
        map_cmd_t c;
        c.cmd         = cmd;
        c.track       = track;
        c.sector      = sector;
        c.drain_first = drain_first;
        cmd_backlog.push_back(c);
        if (address_ok(track, sector)) begin
            if (cmd == CMD_MARK_USED)
                plan_bits[track][sector] = 1'b1;
            else if (cmd == CMD_MARK_FREE)
                plan_bits[track][sector] = 1'b0;
        end
    endtask

    // Mixed command with random address; a share of the addresses fall outside the map.
    task automatic queue_random_cmd(input int bad_pct);
        logic [CMD_W-1:0]   cmd;
        logic [TRACK_W-1:0] track;
        int                 r;
        r = $urandom_range(0, 99);
        if (r < 35)
            cmd = CMD_MARK_USED;
        else if (r < 55)
            cmd = CMD_MARK_FREE;
        else if (r < 75)
            cmd = CMD_QUERY;
        else if (r < 85)
            cmd = CMD_FIND_FREE;
        else if (r < 93)
            cmd = CMD_FREE_SPACE;
        else
            cmd = CMD_TOP_CODE - CMD_W'($urandom_range(0, CMD_TOP_CODE - CMD_FREE_SPACE - 1));
        if ($urandom_range(0, 99) < bad_pct)
            track = TRACK_W'($urandom_range(0, TRACK_MAX));
        else
            track = TRACK_W'($urandom_range(1, DATA_TRACKS));
        queue_cmd(cmd, track, SECTOR_W'($urandom_range(0, SECTOR_MAX)));
    endtask

    task automatic build_stimulus();
        int free_list[$];
        int j;
        int tmp;
        // Directed: empty map, first sector, last sector, repeated marks,
        // invalid tracks and unused command codes.
        queue_cmd(CMD_FREE_SPACE, 0, 0);
        queue_cmd(CMD_FIND_FREE, 0, 0);
        queue_cmd(CMD_QUERY, 1, 0);
        queue_cmd(CMD_MARK_USED, 1, 0);
        queue_cmd(CMD_MARK_USED, 1, 0);
        queue_cmd(CMD_QUERY, 1, 0);
        queue_cmd(CMD_FIND_FREE, TRACK_MAX, SECTOR_MAX);
        queue_cmd(CMD_MARK_USED, TRACK_W'(DATA_TRACKS), SECTOR_MAX);
        queue_cmd(CMD_QUERY, TRACK_W'(DATA_TRACKS), SECTOR_MAX);
        queue_cmd(CMD_FREE_SPACE, TRACK_MAX, SECTOR_MAX);
        queue_cmd(CMD_MARK_FREE, TRACK_W'(DATA_TRACKS), SECTOR_MAX);
        queue_cmd(CMD_MARK_FREE, TRACK_W'(DATA_TRACKS), SECTOR_MAX);
        queue_cmd(CMD_QUERY, TRACK_W'(DATA_TRACKS), SECTOR_MAX);
        queue_cmd(CMD_MARK_USED, 0, 3);
        queue_cmd(CMD_MARK_FREE, 0, 0);
        queue_cmd(CMD_QUERY, 0, SECTOR_MAX);
        queue_cmd(CMD_MARK_USED, TRACK_W'(DATA_TRACKS + 1), 0);
        queue_cmd(CMD_QUERY, TRACK_MAX, SECTOR_MAX);
        queue_cmd(CMD_MARK_FREE, TRACK_MAX, 5);
        for (int c = CMD_FREE_SPACE + 1; c <= CMD_TOP_CODE; c++)
            queue_cmd(CMD_W'(c), TRACK_MAX - TRACK_W'(c), SECTOR_W'(c));
        queue_cmd(CMD_FIND_FREE, 0, 0);

        for (int i = 0; i < 10; i++)
            queue_random_cmd(15);

        // Mark every sector left free in random order, with finds, queries, free-space
        // reads and random commands mixed in, which may free some sectors again.
        for (int t = 1; t <= DATA_TRACKS; t++)
            for (int s = 0; s < SECTORS; s++)
                if (!plan_bits[t][s])
                    free_list.push_back(t * SECTORS + s);
        for (int i = free_list.size() - 1; i > 0; i--) begin
            j            = $urandom_range(0, i);
            tmp          = free_list[i];
            free_list[i] = free_list[j];
            free_list[j] = tmp;
        end
        foreach (free_list[i]) begin
            queue_cmd(CMD_MARK_USED, TRACK_W'(free_list[i] / SECTORS),
                      SECTOR_W'(free_list[i] % SECTORS), i == free_list.size() / 2);
            case ($urandom_range(0, 99))
                0: queue_cmd(CMD_FIND_FREE, TRACK_W'($urandom_range(0, TRACK_MAX)),
                             SECTOR_W'($urandom_range(0, SECTOR_MAX)));
                1: queue_cmd(CMD_QUERY, TRACK_W'(free_list[i] / SECTORS),
                             SECTOR_W'(free_list[i] % SECTORS));
                2: queue_cmd(CMD_FREE_SPACE, 0, 0);
                3: queue_random_cmd(50);
                default: ;
            endcase
        end
        queue_cmd(CMD_FIND_FREE, 0, 0);
        queue_cmd(CMD_FREE_SPACE, 0, 0);
        queue_cmd(CMD_MARK_USED, TRACK_W'($urandom_range(1, DATA_TRACKS)),
                  SECTOR_W'($urandom_range(0, SECTOR_MAX)));
        queue_cmd(CMD_FIND_FREE, TRACK_MAX, SECTOR_MAX);

        // Release a few sectors again, waiting first for the full-map replies.
        for (int i = 0; i < 10; i++) begin
            queue_cmd(CMD_MARK_FREE, TRACK_W'($urandom_range(1, DATA_TRACKS)),
                      SECTOR_W'($urandom_range(0, SECTOR_MAX)), i == 0);
            if ($urandom_range(0, 1) == 0)
                queue_cmd(CMD_FIND_FREE, 0, 0);
        end
        for (int i = 0; i < 10; i++)
            queue_random_cmd(10);
    endtask

    // Sender: a new beat is offered on the falling edge once the last one was taken.
    always @(negedge aclk) begin : tx_driver
        map_cmd_t nxt;
        bit       go;
        go = 1'b0;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !in_taken)) begin
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
            end else if (cmd_backlog.size() != 0) begin
                if (cmd_backlog[0].drain_first && replies_due.size() != 0) begin
                    go = 1'b0;
                end else if (!quiet_tail && tx_idle_pct != 0
                             && $urandom_range(0, 99) < tx_idle_pct) begin
                    tx_gap <= $urandom_range(1, 6) - 1;
                end else begin
                    go = 1'b1;
                end
            end
            if (go) begin
                nxt      = cmd_backlog.pop_front();
                s_cmd    <= nxt.cmd;
                s_track  <= nxt.track;
                s_sector <= nxt.sector;
                s_valid  <= 1'b1;
                if ($urandom_range(0, 63) == 0)
                    tx_idle_pct <= pick_idle_pct();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random short stalls plus two long hold-offs that back the core up.
    always @(negedge aclk) begin : rx_driver
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else if (long_stalls < 2
                     && results_seen >= FIRST_STALL_AT + long_stalls * STALL_SPACING) begin
            long_stalls <= long_stalls + 1;
            rx_hold     <= LONG_STALL - 1;
            m_ready     <= 1'b0;
        end else if (!quiet_tail && rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            rx_hold <= $urandom_range(1, 6) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 199) == 0)
                rx_idle_pct <= pick_idle_pct();
        end
    end

    always @(posedge aclk) begin : monitor
        sab_res_t want;
        if (aresetn) begin
            in_taken   <= s_valid && s_ready;
            quiet_tail <= cmd_backlog.size() < TAIL_ITEMS;
            if (m_valid && m_ready) begin
                results_seen++;
                if (replies_due.size() == 0) begin
                    $error("result beat arrived with no command outstanding");
                    error_count++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("is_used", 32'(want.is_used), 32'(m_is_used));
                    check_field("found_track", 32'(want.found_track), 32'(m_found_track));
                    check_field("found_sector", 32'(want.found_sector), 32'(m_found_sector));
                    check_field("no_space", 32'(want.no_space), 32'(m_no_space));
                    check_field("free_bytes", 32'(want.free_bytes), 32'(m_free_bytes));
                    check_field("bad_address", 32'(want.bad_address), 32'(m_bad_address));
                end
            end
            if (s_valid && s_ready) begin
                want = apply_to_map(s_cmd, s_track, s_sector);
                replies_due.push_back(want);
                cmds_taken++;
                if (s_cmd == CMD_FIND_FREE)
                    finds_taken++;
                if (want.no_space)
                    finds_full++;
                if (want.bad_address)
                    bad_taken++;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat on either channel for %0d cycles", idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        build_stimulus();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        while (cmd_backlog.size() != 0 || s_valid || replies_due.size() != 0)
            @(posedge aclk);
        // Let a late or spurious beat show up before closing.
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Covered %0d commands: %0d finds, %0d of them on a full map, %0d bad addresses.",
                 cmds_taken, finds_taken, finds_full, bad_taken);
        $display("Checked %0d result beats; %0d field errors.", results_seen, error_count);
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sab_pkg.sv
hw/rtl/sab_ram.sv
hw/rtl/sab_engine.sv
hw/rtl/sector_allocation_bitmap_core.sv
sim/testbench.sv
